// ===== hw/rtl/assert_macros.svh =====
// Assertion helper macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/mtds_pkg.sv =====
`default_nettype none
package mtds_pkg;
  localparam int SampleW = 12;
  localparam int TempW   = 9;
  localparam int TdsW    = 18;
  localparam int MedW    = 12;
  localparam int VoltW   = 20;
  localparam logic [TdsW-1:0] TdsMax = 18'd200000;

  typedef struct packed {
    logic [MedW-1:0]  median;
    logic [TempW-1:0] temp;
  } mtds_job_t;

  typedef struct packed {
    logic [TdsW-1:0] tds;
    logic            sat;
  } mtds_res_t;
endpackage
`default_nettype wire

// ===== hw/rtl/mtds_ram.sv =====
`default_nettype none
module mtds_ram #(
  parameter int Width = 12,
  parameter int Depth = 30
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/mtds_front.sv =====
`default_nettype none
// Front end: stores the sample, then finds the median by rank counting.
// Each candidate entry is compared against every entry, one per cycle.
module mtds_front #(
  parameter int WindowSize = 30
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [11:0]             in_sample,
  input  wire logic [8:0]              temp,
  output logic                         job_valid,
  input  wire logic                    job_ready,
  output mtds_pkg::mtds_job_t          job
);
  import mtds_pkg::*;

  localparam int IdxW = $clog2(WindowSize);
  localparam int CntW = $clog2(WindowSize + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(WindowSize - 1);
  localparam logic [CntW-1:0] ScanEnd = CntW'(WindowSize);
  localparam logic [CntW-1:0] LoRank = CntW'((WindowSize - 1) / 2);
  localparam logic [CntW-1:0] HiRank = CntW'(WindowSize / 2);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLR  = 3'd1;
  localparam logic [2:0] S_CAND = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [IdxW-1:0]   wpos_r, wpos_nxt;
  logic [IdxW-1:0]   cand_r, cand_nxt;
  logic [CntW-1:0]   scan_r, scan_nxt;
  logic [CntW-1:0]   less_r, less_nxt, eq_r, eq_nxt;
  logic [SampleW-1:0] key_r, key_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic              key_pend_r, key_pend_nxt;
  logic [CntW:0]     le_cnt;
  logic              we;
  logic [IdxW-1:0]   waddr, raddr;
  logic [SampleW-1:0] wdata, rdata;
  logic [SampleW:0]  med_sum;

  mtds_ram #(.Width(SampleW), .Depth(WindowSize)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign job_valid = (state_r == S_OUT);
  assign med_sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign job.median = med_sum[SampleW:1];
  assign job.temp   = temp;
  assign le_cnt    = {1'b0, less_r} + {1'b0, eq_r};

  // Sequencer for the clearing pass and the rank search.
  always_comb begin
    state_nxt = state_r; wpos_nxt = wpos_r; cand_nxt = cand_r; scan_nxt = scan_r;
    less_nxt = less_r; eq_nxt = eq_r; key_nxt = key_r; lo_nxt = lo_r; hi_nxt = hi_r;
    rd_pend_nxt = 1'b0; key_pend_nxt = 1'b0;
    we = 1'b0; waddr = wpos_r; wdata = in_sample; raddr = scan_r[IdxW-1:0];
    case (state_r)
      S_CLR: begin
        we = 1'b1; waddr = cand_r; wdata = '0;
        if (cand_r == LastIdx) begin
          state_nxt = S_IDLE; cand_nxt = '0;
        end else cand_nxt = cand_r + 1'b1;
      end
      S_IDLE: begin
        if (in_valid) begin
          we = 1'b1;
          wpos_nxt = (wpos_r == LastIdx) ? '0 : wpos_r + 1'b1;
          cand_nxt = '0;
          state_nxt = S_CAND;
        end
      end
      S_CAND: begin
        // Fetch the candidate; scan starts next.
        raddr = cand_r; key_pend_nxt = 1'b1; scan_nxt = '0;
        less_nxt = '0; eq_nxt = '0; state_nxt = S_SCAN;
      end
      S_SCAN: begin
        // The key arrives first, then one window entry per cycle.
        if (key_pend_r) key_nxt = rdata;
        if (rd_pend_r) begin
          if (rdata < key_r) less_nxt = less_r + 1'b1;
          else if (rdata == key_r) eq_nxt = eq_r + 1'b1;
        end
        raddr = scan_r[IdxW-1:0];
        if (scan_r != ScanEnd) begin
          rd_pend_nxt = 1'b1;
          scan_nxt = scan_r + 1'b1;
        end else if (rd_pend_r) state_nxt = S_DONE;
      end
      S_DONE: begin
        // Candidate covers ranks less .. less+eq-1.
        if (less_r <= LoRank && {1'b0, LoRank} < le_cnt) lo_nxt = key_r;
        if (less_r <= HiRank && {1'b0, HiRank} < le_cnt) hi_nxt = key_r;
        if (cand_r == LastIdx) state_nxt = S_OUT;
        else begin
          cand_nxt = cand_r + 1'b1; state_nxt = S_CAND;
        end
      end
      S_OUT: if (job_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; wpos_r <= '0; cand_r <= '0; scan_r <= '0;
      rd_pend_r <= 1'b0; key_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt; wpos_r <= wpos_nxt; cand_r <= cand_nxt; scan_r <= scan_nxt;
      rd_pend_r <= rd_pend_nxt; key_pend_r <= key_pend_nxt;
    end
    less_r <= less_nxt; eq_r <= eq_nxt; key_r <= key_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/mtds_queue.sv =====
`default_nettype none
// Two-entry queue between the front end and the curve unit.
module mtds_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  output logic                     full,
  input  wire mtds_pkg::mtds_job_t wdata,
  input  wire logic                pop,
  output logic                     empty,
  output mtds_pkg::mtds_job_t      rdata
);
  import mtds_pkg::*;
  mtds_job_t ent_r [2];
  logic      rp_r, rp_nxt, wp_r, wp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic      do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rdata   = ent_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rp_nxt  = rp_r ^ do_pop;
  assign wp_nxt  = wp_r ^ do_push;
  assign cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r <= 1'b0; wp_r <= 1'b0; cnt_r <= '0;
    end else begin
      rp_r <= rp_nxt; wp_r <= wp_nxt; cnt_r <= cnt_nxt;
    end
    if (do_push) ent_r[wp_r] <= wdata;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/mtds_back.sv =====
`default_nettype none
// Back end: serial divider for the volts, then the cubic curve with one
// multiplier step per cycle, and a one-entry result register.
module mtds_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                job_valid,
  output logic                     job_ready,
  input  wire mtds_pkg::mtds_job_t job,
  output logic                     res_valid,
  input  wire logic                res_pop,
  output mtds_pkg::mtds_res_t      res
);
  import mtds_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_CU   = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;
  localparam logic [2:0] S_SCL  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_RES  = 3'd7;

  logic [2:0]  state_r, state_nxt;
  logic [4:0]  bit_r, bit_nxt;
  logic [26:0] num_r, num_nxt;     // median*26400 < 2^27; quotient < 2^19
  logic [9:0]  den_r, den_nxt;
  logic [10:0] rem_r, rem_nxt;
  logic [VoltW-1:0] v_r, v_nxt;
  logic [21:0] v2_r, v2_nxt;
  logic [24:0] v3_r, v3_nxt;
  logic [41:0] s_r, s_nxt;
  logic [19:0] q_r, q_nxt;
  logic [TdsW-1:0] tds_r, tds_nxt;
  logic        sat_r, sat_nxt;
  logic [11:0] rem_sh;
  logic [41:0] prod;
  logic [41:0] pos, neg;
  logic [41:0] s_rnd;
  logic [51:0] q_prod;

  assign job_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RES);
  assign res.tds   = tds_r;
  assign res.sat   = sat_r;
  assign rem_sh    = {rem_r, num_r[26]};
  assign prod      = (state_r == S_SQ) ?
                     42'(num_r[VoltW-1:0]) * 42'(num_r[VoltW-1:0]) :
                     42'(v2_r) * 42'(v_r);
  assign pos       = 42'(v3_r) * 42'd66710 + 42'(v_r) * 42'd428695;
  assign neg       = 42'(v2_r) * 42'd127930;
  // Rounded division by 100*2^16: shift by 16, then multiply by ceil(2^32/100).
  assign s_rnd     = s_r + 42'd3276800;
  assign q_prod    = 52'(s_rnd[41:16]) * 52'd42949673;

  always_comb begin
    state_nxt = state_r; bit_nxt = bit_r; num_nxt = num_r; den_nxt = den_r;
    rem_nxt = rem_r; v_nxt = v_r; v2_nxt = v2_r; v3_nxt = v3_r; s_nxt = s_r;
    q_nxt = q_r; tds_nxt = tds_r; sat_nxt = sat_r;
    case (state_r)
      S_IDLE: if (job_valid) begin
        num_nxt = 27'(job.median) * 27'd26400;
        den_nxt = 10'd250 + {1'b0, job.temp};
        rem_nxt = '0; bit_nxt = '0; state_nxt = S_DIV;
      end
      S_DIV: begin
        // Restoring division, one quotient bit per cycle.
        if (rem_sh >= {2'b0, den_r}) begin
          rem_nxt = 11'(rem_sh - {2'b0, den_r}); num_nxt = {num_r[25:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[10:0]; num_nxt = {num_r[25:0], 1'b0};
        end
        bit_nxt = bit_r + 1'b1;
        if (bit_r == 5'd26) state_nxt = S_SQ;
      end
      S_SQ: begin
        // Volts from the quotient, and its square in the same step.
        v_nxt = num_r[VoltW-1:0]; v2_nxt = prod[37:16];
        state_nxt = S_CU;
      end
      S_CU: begin
        v3_nxt = prod[40:16]; state_nxt = S_SUM;
      end
      S_SUM: begin
        s_nxt = (pos >= neg) ? pos - neg : '0;
        state_nxt = S_SCL;
      end
      S_SCL: begin
        q_nxt = q_prod[51:32]; state_nxt = S_FIN;
      end
      S_FIN: begin
        sat_nxt = 1'b0;
        if (q_r < 20'd43) tds_nxt = '0;
        else if (q_r - 20'd43 > 20'(TdsMax)) begin
          tds_nxt = TdsMax; sat_nxt = 1'b1;
        end else tds_nxt = TdsW'(q_r - 20'd43);
        state_nxt = S_RES;
      end
      S_RES: if (res_pop) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Only the state is reset; the datapath is loaded before use.
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
    bit_r <= bit_nxt; num_r <= num_nxt; den_r <= den_nxt; rem_r <= rem_nxt;
    v_r <= v_nxt; v2_r <= v2_nxt; v3_r <= v3_nxt; s_r <= s_nxt; q_r <= q_nxt;
    tds_r <= tds_nxt; sat_r <= sat_nxt;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/median_tds_converter.sv =====
`default_nettype none
// Channel  | Ports                                   | Transfer
// input    | in_push, in_full, in_adc_sample         | push && !full
// result   | out_pop, out_empty, out_tds_tenths_ppm, out_saturated | pop && !empty
// config   | cfg_we, cfg_temperature_tenths          | cfg_we
// The front end ranks the window for each item, plus any wait for room in the queue.
// The back end runs alongside, taking each job through divider and curve to a result.
// After reset a clearing pass zeroes the window; in_full is high during it.
// Either side may stall; a two-entry queue separates the two parts.
module median_tds_converter #(
  parameter int WindowSize = 30
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [11:0] in_adc_sample,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [17:0]      out_tds_tenths_ppm,
  output logic             out_saturated,
  input  wire logic        cfg_we,
  input  wire logic [8:0]  cfg_temperature_tenths
);
  import mtds_pkg::*;

  logic [TempW-1:0] temp_r;
  logic f_valid, f_ready, q_full, q_empty, b_ready, r_valid;
  mtds_job_t f_job, q_job;
  mtds_res_t res;

  // Temperature register.
  always_ff @(posedge clk) begin
    if (!rst_n) temp_r <= 9'd250;
    else if (cfg_we) temp_r <= cfg_temperature_tenths;
  end

  mtds_front #(.WindowSize(WindowSize)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_push), .in_ready(f_ready),
    .in_sample(in_adc_sample), .temp(temp_r),
    .job_valid(f_valid), .job_ready(!q_full), .job(f_job)
  );

  mtds_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(f_valid), .full(q_full), .wdata(f_job),
    .pop(b_ready), .empty(q_empty), .rdata(q_job)
  );

  mtds_back u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(!q_empty), .job_ready(b_ready), .job(q_job),
    .res_valid(r_valid), .res_pop(out_pop), .res(res)
  );

  assign in_full            = !f_ready;
  assign out_empty          = !r_valid;
  assign out_tds_tenths_ppm = res.tds;
  assign out_saturated      = res.sat;
endmodule
`default_nettype wire

// ===== hw/rtl/mtds_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
// Port-level checks on the converter.
module mtds_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_push,
  input wire logic        in_full,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [17:0] out_tds_tenths_ppm,
  input wire logic        out_saturated
);
  // Saturation flag only with the clipped maximum.
  `ASSERT_CLK(a_sat_max, clk, rst_n, (!out_empty && out_saturated) |-> (out_tds_tenths_ppm == 18'd200000), "saturated without maximum")
  // Values never exceed the limit.
  `ASSERT_CLK(a_range, clk, rst_n, !out_empty |-> (out_tds_tenths_ppm <= 18'd200000), "result out of range")
  // A waiting result holds until its transfer.
  `ASSERT_CLK(a_hold, clk, rst_n, ($past(!out_empty && !out_pop)) |-> (!out_empty && $stable(out_tds_tenths_ppm)), "result changed while waiting")
  // An accepted item makes the input side busy next.
  `ASSERT_CLK(a_busy, clk, rst_n, (in_push && !in_full) |=> in_full, "input not busy after transfer")
endmodule

bind median_tds_converter mtds_checker u_mtds_checker (
  .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
  .out_empty(out_empty), .out_pop(out_pop),
  .out_tds_tenths_ppm(out_tds_tenths_ppm), .out_saturated(out_saturated)
);
`default_nettype wire
